[hdl/ledfx_pkg.sv]
// Shared types and constants for the LED strip effect generator.
// Holds the tick, pixel and job structs plus mode and register codes.
// No dependencies; the core, front and back files in hdl/ refer to this package.
`default_nettype none

package ledfx_pkg;

  // Effect modes.
  localparam logic [1:0] MODE_SOLID   = 2'd0;
  localparam logic [1:0] MODE_RAINBOW = 2'd1;
  localparam logic [1:0] MODE_WIPE    = 2'd2;

  // Wipe color steps.
  localparam logic [1:0] STEP_BLUE  = 2'd0;
  localparam logic [1:0] STEP_GREEN = 2'd1;
  localparam logic [1:0] STEP_RED   = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_INTERVAL = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_LOCKOUT  = 1'd1;

  localparam logic [15:0] FRAME_INTERVAL_RESET = 16'd50;
  localparam logic [15:0] PRESS_LOCKOUT_RESET  = 16'd500;

  // Brightness mapping: 1 + (s - 50) * 254 / 973. The product 254 * ceil(2^28 / 973)
  // gives the exact quotient for every sample in range.
  localparam logic [9:0]  SAMPLE_FLOOR = 10'd50;
  localparam logic [26:0] BRIGHT_RECIP = 27'd70074790;
  localparam int unsigned BRIGHT_SHIFT = 28;

  localparam logic [7:0] FULL_ON = 8'd255;

  typedef enum logic [1:0] {
    JOB_SOLID,
    JOB_RAINBOW,
    JOB_WIPE
  } job_kind_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_down;
    logic [9:0]  level_sample;
  } tick_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] brightness;
    logic [1:0] mode_now;
    logic       last_write;
  } pixel_t;

  // One classified request handed from the front to the back.
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] brightness;
    logic [1:0] mode_now;
    logic [7:0] rainbow_offset;
    logic [5:0] wipe_position;
    logic [1:0] wipe_color_step;
  } job_t;

endpackage

`default_nettype wire

[hdl/led_strip_effect_generator_core.sv]
// Top level of the LED strip effect generator: front end, job queue, back end
// and result queue. Depends on ledfx_pkg, ledfx_front, ledfx_fifo, ledfx_back.
`default_nettype none

// Channel   Direction  Handshake              Payload
// tick      in         push / full            ledfx_pkg::tick_t (one control tick)
// pixel     out        empty / pop            ledfx_pkg::pixel_t (one pixel write)
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data (register write)
//
// A tick is classified in the cycle it is pushed; all effect state updates at that edge.
// Its job then waits in a short queue for the back end, which emits one pixel write per cycle
// unless the result queue is full: PIXEL_COUNT writes per solid or rainbow tick, one per wipe
// tick, so the back end's write counter sets the rate. A tick that causes no write leaves nothing
// behind. Reset is synchronous and clears all control and effect state; full rises only when the
// job queue is full, and a stalled pop backs up the result queue and then the back end.

module led_strip_effect_generator_core #(
  parameter int unsigned PIXEL_COUNT  = 8,
  parameter int unsigned JOB_DEPTH    = 2,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire ledfx_pkg::tick_t                  tick,
  output logic                                   empty,
  input  wire logic                              pop,
  output ledfx_pkg::pixel_t                      pixel,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ledfx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [15:0]                       cfg_data
);

  localparam int unsigned JOB_W = $bits(ledfx_pkg::job_t);
  localparam int unsigned PIX_W = $bits(ledfx_pkg::pixel_t);

  logic              accept;
  logic              job_valid;
  ledfx_pkg::job_t   job_new;
  logic [JOB_W-1:0]  job_raw;
  logic              job_empty;
  logic              job_pop;
  logic              res_full;
  logic              res_push;
  ledfx_pkg::pixel_t res;
  logic [PIX_W-1:0]  pixel_raw;

  // A request is taken whenever the job queue has room, even while the back
  // end is still busy with earlier ones.
  assign accept = push & ~full;

  ledfx_front #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .tick      (tick),
    .job_valid (job_valid),
    .job       (job_new)
  );

  // Only ticks that produce writes enter the job queue.
  ledfx_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (accept & job_valid),
    .wdata (job_new),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_raw),
    .empty (job_empty)
  );

  ledfx_back #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_in    (ledfx_pkg::job_t'(job_raw)),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  // The result queue decouples the consumer's pop from the back end.
  ledfx_fifo #(
    .WIDTH (PIX_W),
    .DEPTH (RESULT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (pixel_raw),
    .empty (empty)
  );

  assign pixel = ledfx_pkg::pixel_t'(pixel_raw);

endmodule

`default_nettype wire

[hdl/ledfx_fifo.sv]
// Small register FIFO used for the job queue and the result queue.
// Generic width; no package dependency. DEPTH must be a power of two, at least 2.
`default_nettype none

module ledfx_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

[hdl/ledfx_front.sv]
// Front end: configuration registers, brightness mapping, button handling and
// per-mode state. Classifies each tick into a job. Depends on ledfx_pkg.
`default_nettype none

module ledfx_front #(
  parameter int unsigned PIXEL_COUNT = 8
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ledfx_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [15:0]                          cfg_data,
  input  wire logic                                 accept,
  input  wire ledfx_pkg::tick_t                     tick,
  output logic                                      job_valid,
  output ledfx_pkg::job_t                           job
);

  logic [15:0] frame_interval;
  logic [15:0] press_lockout;
  logic [1:0]  active_mode;
  logic        prev_button;
  logic [31:0] press_time;
  logic        solid_done;
  logic [31:0] rainbow_time;
  logic [7:0]  rainbow_offset;
  logic [31:0] wipe_time;
  logic [5:0]  wipe_position;
  logic [1:0]  wipe_color_step;

  logic [9:0]  sample_above;
  logic [36:0] bright_prod;
  logic [7:0]  bright;
  logic        press_ok;
  logic [1:0]  mode_next;
  logic        rainbow_due;
  logic        wipe_due;
  logic [6:0]  wipe_inc;
  logic        wipe_wrap;
  logic [1:0]  step_next;

  assign cfg_ready = 1'b1;

  // Samples below the floor clamp to it, so they map to brightness 1.
  assign sample_above = (tick.level_sample < ledfx_pkg::SAMPLE_FLOOR) ? '0
                      : tick.level_sample - ledfx_pkg::SAMPLE_FLOOR;
  assign bright_prod  = 37'(sample_above) * 37'(ledfx_pkg::BRIGHT_RECIP);
  assign bright       = bright_prod[ledfx_pkg::BRIGHT_SHIFT +: 8] + 8'd1;

  assign press_ok = tick.button_down & ~prev_button
                  & ((tick.now_ms - press_time) > {16'd0, press_lockout});

  always_comb begin
    mode_next = active_mode;
    if (press_ok) begin
      unique case (active_mode)
        ledfx_pkg::MODE_SOLID:   mode_next = ledfx_pkg::MODE_RAINBOW;
        ledfx_pkg::MODE_RAINBOW: mode_next = ledfx_pkg::MODE_WIPE;
        ledfx_pkg::MODE_WIPE:    mode_next = ledfx_pkg::MODE_SOLID;
        default:                 mode_next = ledfx_pkg::MODE_RAINBOW;
      endcase
    end
  end

  assign rainbow_due = (tick.now_ms - rainbow_time) > {16'd0, frame_interval};
  assign wipe_due    = (tick.now_ms - wipe_time) > {16'd0, frame_interval};

  assign wipe_inc  = {1'b0, wipe_position} + 7'd1;
  assign wipe_wrap = (wipe_inc >= 7'(PIXEL_COUNT));

  always_comb begin
    unique case (wipe_color_step)
      ledfx_pkg::STEP_BLUE:  step_next = ledfx_pkg::STEP_GREEN;
      ledfx_pkg::STEP_GREEN: step_next = ledfx_pkg::STEP_RED;
      ledfx_pkg::STEP_RED:   step_next = ledfx_pkg::STEP_BLUE;
      default:               step_next = ledfx_pkg::STEP_GREEN;
    endcase
  end

  always_comb begin
    job_valid           = 1'b0;
    job.kind            = ledfx_pkg::JOB_SOLID;
    job.brightness      = bright;
    job.mode_now        = mode_next;
    job.rainbow_offset  = rainbow_offset;
    job.wipe_position   = wipe_position;
    job.wipe_color_step = wipe_color_step;
    unique case (mode_next)
      ledfx_pkg::MODE_SOLID: begin
        job_valid = ~solid_done;
        job.kind  = ledfx_pkg::JOB_SOLID;
      end
      ledfx_pkg::MODE_RAINBOW: begin
        job_valid = rainbow_due;
        job.kind  = ledfx_pkg::JOB_RAINBOW;
      end
      ledfx_pkg::MODE_WIPE: begin
        job_valid = wipe_due;
        job.kind  = ledfx_pkg::JOB_WIPE;
      end
      default: begin
        job_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_interval <= ledfx_pkg::FRAME_INTERVAL_RESET;
      press_lockout  <= ledfx_pkg::PRESS_LOCKOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ledfx_pkg::REG_FRAME_INTERVAL: frame_interval <= cfg_data;
        ledfx_pkg::REG_PRESS_LOCKOUT:  press_lockout  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mode     <= ledfx_pkg::MODE_SOLID;
      prev_button     <= 1'b0;
      press_time      <= '0;
      solid_done      <= 1'b0;
      rainbow_time    <= '0;
      rainbow_offset  <= '0;
      wipe_time       <= '0;
      wipe_position   <= '0;
      wipe_color_step <= ledfx_pkg::STEP_BLUE;
    end else if (accept) begin
      active_mode <= mode_next;
      prev_button <= tick.button_down;
      if (press_ok) begin
        press_time <= tick.now_ms;
      end
      if (job_valid) begin
        unique case (job.kind)
          ledfx_pkg::JOB_SOLID: begin
            solid_done <= 1'b1;
          end
          ledfx_pkg::JOB_RAINBOW: begin
            rainbow_offset <= rainbow_offset + 8'd1;
            rainbow_time   <= tick.now_ms;
          end
          ledfx_pkg::JOB_WIPE: begin
            wipe_time <= tick.now_ms;
            if (wipe_wrap) begin
              wipe_position   <= '0;
              wipe_color_step <= step_next;
            end else begin
              wipe_position <= wipe_inc[5:0];
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ledfx_back.sv]
// Back end: expands one job into its pixel writes, one per cycle while the result queue has room.
// Computes color-wheel, solid and wipe colors. Depends on ledfx_pkg.
`default_nettype none

module ledfx_back #(
  parameter int unsigned PIXEL_COUNT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              job_empty,
  input  wire ledfx_pkg::job_t   job_in,
  output logic                   job_pop,
  input  wire logic              res_full,
  output logic                   res_push,
  output ledfx_pkg::pixel_t      res
);

  logic            busy;
  ledfx_pkg::job_t job;
  logic [5:0]      cnt;
  logic            last;
  logic [7:0]      wheel_pos;
  logic [7:0]      wr;
  logic [7:0]      wg;
  logic [7:0]      wb;

  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] w;
    logic [7:0] t;
    logic [9:0] t3;
    logic [7:0] up;
    w  = 8'hFF - pos;
    t  = (w < 8'd85) ? w : ((w < 8'd170) ? w - 8'd85 : w - 8'd170);
    t3 = {2'b00, t} + {1'b0, t, 1'b0};
    up = t3[7:0];
    if (w < 8'd85) begin
      wheel = {8'hFF - up, 8'd0, up};
    end else if (w < 8'd170) begin
      wheel = {8'd0, up, 8'hFF - up};
    end else begin
      wheel = {up, 8'hFF - up, 8'd0};
    end
  endfunction

  assign last     = (job.kind == ledfx_pkg::JOB_WIPE) || (cnt == 6'(PIXEL_COUNT - 1));
  assign res_push = busy & ~res_full;
  assign job_pop  = ~job_empty & (~busy | (res_push & last));

  assign wheel_pos    = job.rainbow_offset + {2'b00, cnt};
  assign {wr, wg, wb} = wheel(wheel_pos);

  always_comb begin
    res.pixel_index = cnt;
    res.brightness  = job.brightness;
    res.mode_now    = job.mode_now;
    res.last_write  = last;
    res.red         = '0;
    res.green       = '0;
    res.blue        = '0;
    case (job.kind)
      ledfx_pkg::JOB_SOLID: begin
        res.red = ledfx_pkg::FULL_ON;
      end
      ledfx_pkg::JOB_RAINBOW: begin
        res.red   = wr;
        res.green = wg;
        res.blue  = wb;
      end
      ledfx_pkg::JOB_WIPE: begin
        res.pixel_index = job.wipe_position;
        case (job.wipe_color_step)
          ledfx_pkg::STEP_GREEN: res.green = ledfx_pkg::FULL_ON;
          ledfx_pkg::STEP_RED:   res.red   = ledfx_pkg::FULL_ON;
          default:               res.blue  = ledfx_pkg::FULL_ON;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (job_pop) begin
      busy <= 1'b1;
    end else if (res_push && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_in;
      cnt <= '0;
    end else if (res_push) begin
      cnt <= cnt + 6'd1;
    end
  end

endmodule

`default_nettype wire
